[src/flh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flh_pkg
// Shared constants, register codes and types of the filename letter hash.
// ----------------------------------------------------------------------------
package flh_pkg;

    localparam int BYTE_W      = 8;
    localparam int LETTER_W    = 7;
    localparam int DATA_W      = 32;
    localparam int RADIX_W     = 5;
    localparam int DIGITS_W    = 4;
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam int MAX_DIGITS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MULT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS  = 2'd3;

    localparam logic [DATA_W-1:0]   RST_MULT    = 32'd31;
    localparam logic [DATA_W-1:0]   RST_MODULUS = 32'd1000003;
    localparam logic [RADIX_W-1:0]  RST_RADIX   = 5'd26;
    localparam logic [DIGITS_W-1:0] RST_DIGITS  = 4'd6;

    localparam logic [RADIX_W-1:0]  RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0]  RADIX_MAX   = 5'd26;

    localparam logic [BYTE_W-1:0]   SLASH_BYTE  = 8'h2F;
    localparam logic [LETTER_W-1:0] LETTER_BASE = 7'h41;
    localparam logic [LETTER_W-1:0] LETTER_TOP  = 7'h5A;

    typedef struct packed {
        logic [BYTE_W-1:0] name_byte;
        logic              is_last;
        logic              is_slash;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]   mult;
        logic [DATA_W-1:0]   modulus;
        logic [RADIX_W-1:0]  radix;
        logic [DIGITS_W-1:0] digits;
    } t_cfg;

endpackage

[src/flh_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flh_in_if / flh_out_if
// Valid/ready channels for path bytes in and letters out.
// ----------------------------------------------------------------------------
interface flh_in_if import flh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] name_byte;
    logic              is_last;

    modport source (output valid, output name_byte, output is_last, input ready);
    modport sink   (input valid, input name_byte, input is_last, output ready);
endinterface

interface flh_out_if import flh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;

    modport source (output valid, output letter, output last_letter, input ready);
    modport sink   (input valid, input letter, input last_letter, output ready);
endinterface

[src/filename_letter_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filename_letter_hash
// Rolling hash of the last path component, emitted as a run of letters.
//
// Bytes of a path arrive on i_byte_if, is_last set on the final byte. Each
// beat lands in a two-entry queue; the hash engine drains it one byte at a
// time. Per byte the hash is multiplied, the byte is added, and the restoring
// divider is loaded and runs its 32 steps to reduce the sum by the modulus
// (a slash clears the hash, a zero modulus skips the divider).
// After the final byte a start state loads the same divider, which splits
// the hash into letters, as many as the digits register gives (clamped to
// 1..MAX_DIGITS), least significant first, one beat each on o_letter_if with
// last_letter on the final one. Letters leave through a single output
// register; when the receiver stalls the engine holds its next letter and
// the queue keeps taking bytes until full. Configuration is written through
// i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must do so only while no name
// is in flight, the block does not enforce it. Synchronous reset restores the
// register defaults, clears the hash and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module filename_letter_hash import flh_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    flh_in_if.sink               i_byte_if,
    flh_out_if.source            o_letter_if,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata
);

    t_cfg  r_cfg;
    logic  q_full;
    logic  q_push;
    t_item q_in;
    logic  q_pop;
    logic  q_valid;
    t_item q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mult    <= RST_MULT;
            r_cfg.modulus <= RST_MODULUS;
            r_cfg.radix   <= RST_RADIX;
            r_cfg.digits  <= RST_DIGITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MULT:    r_cfg.mult    <= i_cfg_wdata;
                CFG_MODULUS: r_cfg.modulus <= i_cfg_wdata;
                CFG_RADIX:   r_cfg.radix   <= i_cfg_wdata[RADIX_W-1:0];
                CFG_DIGITS:  r_cfg.digits  <= i_cfg_wdata[DIGITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    flh_front u_front (
        .i_byte_if (i_byte_if),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_item    (q_in)
    );

    flh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    flh_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out),
        .o_pop       (q_pop),
        .o_letter_if (o_letter_if)
    );

endmodule

[src/flh_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flh_div
// Restoring divider, one quotient bit per cycle; quotient and remainder.
// ----------------------------------------------------------------------------
module flh_div import flh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvs;

    logic [DATA_W:0]   n_shift;
    logic [DATA_W:0]   n_diff;
    logic              n_fit;

    always_comb begin
        n_shift = {r_rem, r_quo[DATA_W-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
        n_fit   = (n_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo  <= {r_quo[DATA_W-2:0], n_fit};
                r_rem  <= n_fit ? n_diff[DATA_W-1:0] : n_shift[DATA_W-1:0];
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

[src/flh_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flh_queue
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module flh_queue import flh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [FILL_W-1:0] r_fill;
    logic              n_push;
    logic              n_pop;

    assign o_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_item  = r_mem[r_rptr];
    assign n_push  = i_push && !o_full;
    assign n_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (n_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (n_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (n_push && !n_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (n_pop && !n_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

endmodule

[src/flh_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flh_front
// Accept path bytes, mark separators, push them into the queue.
// ----------------------------------------------------------------------------
module flh_front import flh_pkg::*; (
    flh_in_if.sink i_byte_if,
    input  logic   i_q_full,
    output logic   o_push,
    output t_item  o_item
);

    assign i_byte_if.ready = !i_q_full;
    assign o_push          = i_byte_if.valid && !i_q_full;

    always_comb begin
        o_item.name_byte = i_byte_if.name_byte;
        o_item.is_last   = i_byte_if.is_last;
        o_item.is_slash  = (i_byte_if.name_byte == SLASH_BYTE);
    end

endmodule

[src/flh_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flh_back
// Update the running hash per byte and emit the letters of a finished name.
// ----------------------------------------------------------------------------
module flh_back import flh_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_pop,
    flh_out_if.source  o_letter_if
);

    localparam int IDX_W = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADD   = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIG   = 3'd4;
    localparam logic [2:0] ST_PUT   = 3'd5;

    logic [2:0]          r_state;
    logic [DATA_W-1:0]   r_hash;
    logic [DATA_W-1:0]   r_prod;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_last;
    logic [DATA_W-1:0]   r_emit;
    logic [RADIX_W-1:0]  r_digit;
    logic [IDX_W-1:0]    r_idx;
    logic                r_div_go;
    logic [DATA_W-1:0]   r_div_a;
    logic [DATA_W-1:0]   r_div_b;
    logic                r_out_valid;
    logic [LETTER_W-1:0] r_letter;
    logic                r_out_last;

    logic                div_done;
    logic [DATA_W-1:0]   div_quot;
    logic [DATA_W-1:0]   div_rem;

    logic [DATA_W-1:0]   n_sum;
    logic [RADIX_W-1:0]  n_radix;
    logic [CNT_W-1:0]    n_count;
    logic                n_final;
    logic                n_out_free;

    flh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_sum = r_prod + DATA_W'(r_byte);
        if (i_cfg.radix < RADIX_MIN) begin
            n_radix = RADIX_MIN;
        end else if (i_cfg.radix > RADIX_MAX) begin
            n_radix = RADIX_MAX;
        end else begin
            n_radix = i_cfg.radix;
        end
        if (i_cfg.digits == '0) begin
            n_count = CNT_W'(1);
        end else if (CNT_W'(i_cfg.digits) > CNT_W'(MAX_DIGITS)) begin
            n_count = CNT_W'(MAX_DIGITS);
        end else begin
            n_count = CNT_W'(i_cfg.digits);
        end
        n_final    = ((CNT_W'(r_idx) + CNT_W'(1)) == n_count);
        n_out_free = !r_out_valid || o_letter_if.ready;
    end

    assign o_pop = (r_state == ST_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= '0;
            r_idx       <= '0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_out_valid && o_letter_if.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_last <= i_q_item.is_last;
                        r_byte <= i_q_item.name_byte;
                        r_prod <= r_hash * i_cfg.mult;
                        if (i_q_item.is_slash) begin
                            r_hash  <= '0;
                            r_state <= i_q_item.is_last ? ST_START : ST_IDLE;
                        end else begin
                            r_state <= ST_ADD;
                        end
                    end
                end
                ST_ADD: begin
                    if (i_cfg.modulus == '0) begin
                        r_hash  <= n_sum;
                        r_state <= r_last ? ST_START : ST_IDLE;
                    end else begin
                        r_div_a  <= n_sum;
                        r_div_b  <= i_cfg.modulus;
                        r_div_go <= 1'b1;
                        r_state  <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (div_done) begin
                        r_hash  <= div_rem;
                        r_state <= r_last ? ST_START : ST_IDLE;
                    end
                end
                ST_START: begin
                    r_hash   <= '0;
                    r_idx    <= '0;
                    r_div_a  <= r_hash;
                    r_div_b  <= DATA_W'(n_radix);
                    r_div_go <= 1'b1;
                    r_state  <= ST_DIG;
                end
                ST_DIG: begin
                    if (div_done) begin
                        r_emit  <= div_quot;
                        r_digit <= div_rem[RADIX_W-1:0];
                        r_state <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_letter    <= LETTER_BASE + LETTER_W'(r_digit);
                        r_out_last  <= n_final;
                        r_idx       <= r_idx + IDX_W'(1);
                        if (n_final) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_div_a  <= r_emit;
                            r_div_b  <= DATA_W'(n_radix);
                            r_div_go <= 1'b1;
                            r_state  <= ST_DIG;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_letter_if.valid       = r_out_valid;
    assign o_letter_if.letter      = r_letter;
    assign o_letter_if.last_letter = r_out_last;

endmodule

[src/flh_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flh_checker
// Port-level checks on the letter channel, bound to the top level.
// ----------------------------------------------------------------------------
module flh_checker import flh_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic [LETTER_W-1:0] i_letter,
    input logic                i_last_letter
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("letter beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_letter) && $stable(i_last_letter))
        else $error("letter beat changed while stalled");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_letter >= LETTER_BASE) && (i_letter <= LETTER_TOP))
        else $error("letter outside A..Z");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("letter valid after reset");

endmodule

bind filename_letter_hash flh_checker u_flh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_letter_if.valid),
    .i_ready       (o_letter_if.ready),
    .i_letter      (o_letter_if.letter),
    .i_last_letter (o_letter_if.last_letter)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for filename_letter_hash. Path bytes go in as beats on
// the byte channel. A scoreboard keeps its own copy of the registers and of
// the running hash, and predicts the letters of each finished name. Each
// letter beat is checked against the oldest prediction. A directed set of
// names and register extremes comes first, then random phases. Each random
// phase writes fresh registers and sends random names to a stalling
// receiver, with bursty input in some phases and a long hold-off in one.
// ----------------------------------------------------------------------------
module tb_top;
    import flh_pkg::*;

    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 800;
    localparam int RAND_BYTES    = 100;
    localparam int MAX_PRINTS    = 200;
    localparam int TIMEOUT_NS    = 1_000_000;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last_letter;
    } t_letter_beat;

    class letter_board;
        logic [DATA_W-1:0]   mult;
        logic [DATA_W-1:0]   modulus;
        logic [RADIX_W-1:0]  radix;
        logic [DIGITS_W-1:0] digits;
        logic [DATA_W-1:0]   name_hash;
        t_letter_beat        letters_due[$];
        int                  n_errors;

        function new();
            mult      = RST_MULT;
            modulus   = RST_MODULUS;
            radix     = RST_RADIX;
            digits    = RST_DIGITS;
            name_hash = '0;
            n_errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                CFG_MULT:    mult    = val;
                CFG_MODULUS: modulus = val;
                CFG_RADIX:   radix   = val[RADIX_W-1:0];
                CFG_DIGITS:  digits  = val[DIGITS_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic last);
            logic [DATA_W-1:0] sum;
            logic [DATA_W-1:0] base;
            logic [DATA_W-1:0] rest;
            int                n;
            t_letter_beat      beat;
            if (b == SLASH_BYTE) begin
                name_hash = '0;
            end else begin
                sum = name_hash * mult + {{(DATA_W-BYTE_W){1'b0}}, b};
                if (modulus != '0) sum = sum % modulus;
                name_hash = sum;
            end
            if (last) begin
                base = (radix < RADIX_MIN) ? DATA_W'(RADIX_MIN) :
                       (radix > RADIX_MAX) ? DATA_W'(RADIX_MAX) : DATA_W'(radix);
                n = (digits == '0) ? 1 :
                    (int'(digits) > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : int'(digits);
                rest = name_hash;
                for (int k = 0; k < n; k++) begin
                    beat.letter      = LETTER_BASE + LETTER_W'(rest % base);
                    beat.last_letter = (k == n - 1);
                    letters_due = {letters_due, beat};
                    rest = rest / base;
                end
                name_hash = '0;
            end
        endfunction

        task report(string msg);
            n_errors++;
            if (n_errors <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_letter(logic [LETTER_W-1:0] got_letter, logic got_last);
            t_letter_beat want;
            if (letters_due.size() == 0) begin
                report($sformatf("letter %h with none predicted", got_letter));
                return;
            end
            want = letters_due.pop_front();
            if (got_letter !== want.letter)
                report($sformatf("letter %h, want %h", got_letter, want.letter));
            if (got_last !== want.last_letter)
                report($sformatf("last_letter %b, want %b", got_last, want.last_letter));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_wdata;

    flh_in_if  byte_if ();
    flh_out_if letter_if ();

    letter_board board;
    bit          sender_steady;
    bit          hold_req;
    int          burst_left;

    filename_letter_hash dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_if   (byte_if),
        .o_letter_if (letter_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready)
                board.take_byte(byte_if.name_byte, byte_if.is_last);
            if (letter_if.valid && letter_if.ready)
                board.check_letter(letter_if.letter, letter_if.last_letter);
        end
    end

    // receiver: random stall pattern, plus a long hold-off on request
    initial begin
        int mode = 0;
        int span = 0;
        int hold = 0;
        letter_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(16, 96);
            end
            span--;
            if (hold > 0) begin
                hold--;
                letter_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       letter_if.ready <= 1'b1;
                    1:       letter_if.ready <= ($urandom_range(0, 3) != 0);
                    default: letter_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0 && !sender_steady) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        byte_if.valid     <= 1'b1;
        byte_if.name_byte <= b;
        byte_if.is_last   <= last;
        do @(posedge i_clk); while (!byte_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_path(input string path);
        for (int i = 0; i < path.len(); i++)
            send_byte(path[i], i == path.len() - 1);
    endtask

    task automatic drain();
        byte_if.valid <= 1'b0;
        while (board.letters_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [DATA_W-1:0] mult, input logic [DATA_W-1:0] modulus,
                             input logic [DATA_W-1:0] radix, input logic [DATA_W-1:0] digits);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [DATA_W-1:0]    val[4];
        idx = '{CFG_MULT, CFG_MODULUS, CFG_RADIX, CFG_DIGITS};
        val = '{mult, modulus, radix, digits};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx[i];
            i_cfg_wdata <= val[i];
            @(posedge i_clk);
            board.write_reg(idx[i], val[i]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int                  sent;
        int                  phase;
        int                  names;
        int                  len;
        int                  pick;
        logic [DATA_W-1:0]   mult;
        logic [DATA_W-1:0]   modulus;
        logic [BYTE_W-1:0]   b;

        board = new();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_MULT;
        i_cfg_wdata       = '0;
        byte_if.valid     = 1'b0;
        byte_if.name_byte = '0;
        byte_if.is_last   = 1'b0;
        sender_steady     = 1'b0;
        hold_req          = 1'b0;
        burst_left        = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset registers
        send_path("ab");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(SLASH_BYTE, 1'b1);
        send_path("x/y");
        drain();

        // directed: register extremes and clamping
        write_cfg('1, '0, 32'd27, 32'd9);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b1);
        drain();
        write_cfg('0, 32'd1, 32'd0, 32'd0);
        send_path("q");
        drain();
        write_cfg('1, '1, 32'd2, 32'd8);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        drain();
        write_cfg(32'd31, '0, 32'd31, 32'd1);
        send_byte(8'h7A, 1'b0);
        send_byte(SLASH_BYTE, 1'b1);
        drain();
        write_cfg(RST_MULT, RST_MODULUS, 32'd1, 32'd15);
        send_path("k9");
        drain();

        // random phases
        sent  = 0;
        phase = 0;
        while (sent < RAND_BYTES || phase < 3) begin
            case ($urandom_range(0, 4))
                0:       mult = RST_MULT;
                1:       mult = '0;
                2:       mult = '1;
                default: mult = $urandom();
            endcase
            case ($urandom_range(0, 6))
                0:       modulus = RST_MODULUS;
                1:       modulus = '0;
                2:       modulus = 32'd1;
                3:       modulus = '1;
                4:       modulus = $urandom_range(2, 1000);
                default: modulus = $urandom();
            endcase
            write_cfg(mult, modulus,
                      ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(2, 26),
                      ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 8));
            sender_steady = (phase == 2) || ($urandom_range(0, 3) == 0);
            if (phase == 2) hold_req = 1'b1;
            names = (phase == 2) ? 4 : $urandom_range(2, 5);
            for (int n = 0; n < names; n++) begin
                len = (phase == 2) ? 6 :
                      ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 3)      b = SLASH_BYTE;
                    else if (pick < 8) b = BYTE_W'($urandom_range(0, 255));
                    else               b = BYTE_W'($urandom_range(8'h30, 8'h7A));
                    send_byte(b, i == len - 1);
                    sent++;
                end
            end
            drain();
            phase++;
        end

        if (board.n_errors == 0 && board.letters_due.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[filename_letter_hash.f]
src/flh_pkg.sv
src/flh_ifs.sv
src/flh_div.sv
src/flh_queue.sv
src/flh_front.sv
src/flh_back.sv
src/filename_letter_hash.sv
src/flh_checker.sv
tb/sv/tb_top.sv
